[hw/rtl/event_info_section_parser_core_macros.svh]
// Assertion helpers used by the parser core's result buffer.
`ifndef EVENT_INFO_SECTION_PARSER_CORE_MACROS_SVH
`define EVENT_INFO_SECTION_PARSER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define EISP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every rising clock edge, reset included.
`define EISP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/eisp_pkg.sv]
package eisp_pkg;

  localparam int unsigned CodeW   = 5;
  localparam int unsigned ValueW  = 40;
  localparam int unsigned EventW  = 9;
  localparam int unsigned DescW   = 11;
  localparam int unsigned MaxRecs = 3;
  localparam int unsigned CntW    = 2;

  typedef enum logic [CodeW-1:0] {
    FC_TABLE_ID      = 5'd0,
    FC_SECTION_LEN   = 5'd1,
    FC_SERVICE_ID    = 5'd2,
    FC_VERSION       = 5'd3,
    FC_CURRENT_NEXT  = 5'd4,
    FC_SECTION_NUM   = 5'd5,
    FC_LAST_SECTION  = 5'd6,
    FC_TS_ID         = 5'd7,
    FC_NETWORK_ID    = 5'd8,
    FC_SEG_LAST_SECT = 5'd9,
    FC_LAST_TABLE_ID = 5'd10,
    FC_EVENT_ID      = 5'd11,
    FC_START_TIME    = 5'd12,
    FC_DURATION      = 5'd13,
    FC_RUNNING       = 5'd14,
    FC_LOOP_LEN      = 5'd15,
    FC_DESC_TAG      = 5'd16,
    FC_DESC_LEN      = 5'd17,
    FC_END           = 5'd18
  } field_code_e;

  typedef struct packed {
    field_code_e        code;
    logic [ValueW-1:0]  value;
    logic [EventW-1:0]  event_num;
    logic [DescW-1:0]   desc_num;
  } rec_t;

  // All records caused by one byte, in emission order.
  typedef struct packed {
    logic [CntW-1:0]     n;
    rec_t [MaxRecs-1:0]  recs;
  } grp_t;

endpackage

[hw/rtl/eisp_parser.sv]
module eisp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                section_start_i,
  output eisp_pkg::grp_t      grp_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_EVENT,
    PH_DTAG,
    PH_DLEN,
    PH_DBODY,
    PH_SKIP,
    PH_IDLE
  } phase_e;

  phase_e      ph_q, ph_d;
  logic [12:0] pos_q, pos_d;
  logic [11:0] slen_q, slen_d;
  logic [3:0]  evpos_q, evpos_d;
  logic [11:0] loop_q, loop_d;
  logic [8:0]  dleft_q, dleft_d;
  logic [8:0]  evidx_q, evidx_d;
  logic [10:0] didx_q, didx_d;
  logic [39:0] acc_q, acc_d;

  always_comb begin
    phase_e          ph_c;
    logic [12:0]     pos_c;
    logic [11:0]     slen_c, loop_c, loop_dec;
    logic [3:0]      evpos_c;
    logic [8:0]      dleft_c, evidx_c;
    logic [10:0]     didx_c;
    logic [39:0]     acc_c;
    logic [13:0]     pos_inc;
    logic [12:0]     end_pos;
    logic [1:0]      nrec;
    logic            next_ev;
    eisp_pkg::grp_t  g;

    ph_c    = section_start_i ? PH_HEADER : ph_q;
    pos_c   = section_start_i ? '0 : pos_q;
    slen_c  = section_start_i ? '0 : slen_q;
    evpos_c = section_start_i ? '0 : evpos_q;
    loop_c  = section_start_i ? '0 : loop_q;
    dleft_c = section_start_i ? '0 : dleft_q;
    evidx_c = section_start_i ? '0 : evidx_q;
    didx_c  = section_start_i ? '0 : didx_q;
    acc_c   = section_start_i ? '0 : acc_q;

    ph_d    = ph_c;
    pos_d   = pos_c;
    slen_d  = slen_c;
    evpos_d = evpos_c;
    loop_d  = loop_c;
    dleft_d = dleft_c;
    evidx_d = evidx_c;
    didx_d  = didx_c;
    acc_d   = acc_c;

    g        = '0;
    nrec     = '0;
    next_ev  = 1'b0;
    loop_dec = loop_c - 12'd1;
    pos_inc  = {1'b0, pos_c} + 14'd1;
    end_pos  = '0;

    if (ph_c != PH_IDLE) begin
      acc_d = {acc_c[31:0], data_byte_i};

      // Stop event parsing once the CRC area is reached.
      if ((ph_c inside {PH_EVENT, PH_DTAG, PH_DLEN, PH_DBODY}) &&
          pos_inc >= {2'b00, slen_c}) begin
        ph_d = PH_SKIP;
      end

      case (ph_d)
        PH_HEADER: begin
          case (pos_c)
            13'd0: begin
              g.recs[nrec] = '{eisp_pkg::FC_TABLE_ID, 40'(data_byte_i), '0, '0};
              nrec = nrec + 2'd1;
            end
            13'd2: begin
              slen_d = acc_d[11:0];
              g.recs[nrec] = '{eisp_pkg::FC_SECTION_LEN, 40'(acc_d[11:0]), '0, '0};
              nrec = nrec + 2'd1;
            end
            13'd4: begin
              g.recs[nrec] = '{eisp_pkg::FC_SERVICE_ID, 40'(acc_d[15:0]), '0, '0};
              nrec = nrec + 2'd1;
            end
            13'd5: begin
              g.recs[nrec] = '{eisp_pkg::FC_VERSION, 40'(data_byte_i[5:1]), '0, '0};
              nrec = nrec + 2'd1;
              g.recs[nrec] = '{eisp_pkg::FC_CURRENT_NEXT, 40'(data_byte_i[0]), '0, '0};
              nrec = nrec + 2'd1;
            end
            13'd6: begin
              g.recs[nrec] = '{eisp_pkg::FC_SECTION_NUM, 40'(data_byte_i), '0, '0};
              nrec = nrec + 2'd1;
            end
            13'd7: begin
              g.recs[nrec] = '{eisp_pkg::FC_LAST_SECTION, 40'(data_byte_i), '0, '0};
              nrec = nrec + 2'd1;
            end
            13'd9: begin
              g.recs[nrec] = '{eisp_pkg::FC_TS_ID, 40'(acc_d[15:0]), '0, '0};
              nrec = nrec + 2'd1;
            end
            13'd11: begin
              g.recs[nrec] = '{eisp_pkg::FC_NETWORK_ID, 40'(acc_d[15:0]), '0, '0};
              nrec = nrec + 2'd1;
            end
            13'd12: begin
              g.recs[nrec] = '{eisp_pkg::FC_SEG_LAST_SECT, 40'(data_byte_i), '0, '0};
              nrec = nrec + 2'd1;
            end
            13'd13: begin
              g.recs[nrec] = '{eisp_pkg::FC_LAST_TABLE_ID, 40'(data_byte_i), '0, '0};
              nrec = nrec + 2'd1;
              ph_d    = PH_EVENT;
              evpos_d = '0;
            end
            default: ;
          endcase
        end
        PH_EVENT: begin
          if (evpos_c == 4'd0 && data_byte_i == 8'hff) begin
            ph_d = PH_SKIP;
          end else begin
            case (evpos_c)
              4'd1: begin
                g.recs[nrec] = '{eisp_pkg::FC_EVENT_ID, 40'(acc_d[15:0]), evidx_c, '0};
                nrec = nrec + 2'd1;
              end
              4'd6: begin
                g.recs[nrec] = '{eisp_pkg::FC_START_TIME, acc_d, evidx_c, '0};
                nrec = nrec + 2'd1;
              end
              4'd9: begin
                g.recs[nrec] = '{eisp_pkg::FC_DURATION, 40'(acc_d[23:0]), evidx_c, '0};
                nrec = nrec + 2'd1;
              end
              4'd10: begin
                g.recs[nrec] = '{eisp_pkg::FC_RUNNING, 40'(data_byte_i[7:5]), evidx_c, '0};
                nrec = nrec + 2'd1;
              end
              default: ;
            endcase
            if (evpos_c >= 4'd11) begin
              loop_d = acc_d[11:0];
              g.recs[nrec] = '{eisp_pkg::FC_LOOP_LEN, 40'(acc_d[11:0]), evidx_c, '0};
              nrec = nrec + 2'd1;
              if (acc_d[11:0] == 12'd0) begin
                next_ev = 1'b1;
              end else begin
                didx_d = '0;
                ph_d   = PH_DTAG;
              end
            end else begin
              evpos_d = evpos_c + 4'd1;
            end
          end
        end
        PH_DTAG: begin
          g.recs[nrec] = '{eisp_pkg::FC_DESC_TAG, 40'(data_byte_i), evidx_c, didx_c};
          nrec   = nrec + 2'd1;
          loop_d = loop_dec;
          if (loop_dec == 12'd0) begin
            next_ev = 1'b1;
          end else begin
            ph_d = PH_DLEN;
          end
        end
        PH_DLEN: begin
          g.recs[nrec] = '{eisp_pkg::FC_DESC_LEN, 40'(data_byte_i), evidx_c, didx_c};
          nrec    = nrec + 2'd1;
          loop_d  = loop_dec;
          dleft_d = 9'(data_byte_i);
          if (loop_dec == 12'd0) begin
            next_ev = 1'b1;
          end else if (data_byte_i == 8'd0) begin
            didx_d = didx_c + 11'd1;
            ph_d   = PH_DTAG;
          end else begin
            ph_d = PH_DBODY;
          end
        end
        PH_DBODY: begin
          loop_d  = loop_dec;
          dleft_d = dleft_c - 9'd1;
          if (loop_dec == 12'd0) begin
            next_ev = 1'b1;
          end else if (dleft_d == 9'd0) begin
            didx_d = didx_c + 11'd1;
            ph_d   = PH_DTAG;
          end
        end
        default: ;
      endcase

      if (next_ev) begin
        evidx_d = evidx_c + 9'd1;
        didx_d  = '0;
        evpos_d = '0;
        ph_d    = PH_EVENT;
      end

      // The byte at section length plus two closes the section.
      end_pos = {1'b0, slen_d} + 13'd2;
      if (pos_c >= 13'd2 && pos_c == end_pos) begin
        g.recs[nrec] = '{eisp_pkg::FC_END, '0, '0, '0};
        nrec = nrec + 2'd1;
        ph_d = PH_IDLE;
      end else begin
        pos_d = pos_c + 13'd1;
      end
    end

    g.n   = nrec;
    grp_o = g;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_HEADER;
      pos_q   <= '0;
      slen_q  <= '0;
      evpos_q <= '0;
      loop_q  <= '0;
      dleft_q <= '0;
      evidx_q <= '0;
      didx_q  <= '0;
      acc_q   <= '0;
    end else if (fire_i) begin
      ph_q    <= ph_d;
      pos_q   <= pos_d;
      slen_q  <= slen_d;
      evpos_q <= evpos_d;
      loop_q  <= loop_d;
      dleft_q <= dleft_d;
      evidx_q <= evidx_d;
      didx_q  <= didx_d;
      acc_q   <= acc_d;
    end
  end

endmodule

[hw/rtl/eisp_out_buf.sv]
`include "event_info_section_parser_core_macros.svh"

module eisp_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  eisp_pkg::grp_t  grp_i,
  output logic            can_load_o,
  output eisp_pkg::rec_t  rec_o,
  output logic            out_valid_o,
  output logic            last_o,
  input  logic            out_ready_i
);

  eisp_pkg::rec_t [eisp_pkg::MaxRecs-1:0] slots_q, slots_d;
  logic [eisp_pkg::CntW-1:0]              cnt_q, cnt_d;
  logic                                   pop;

  assign pop        = (cnt_q != '0) && out_ready_i;
  assign can_load_o = (cnt_q == '0) || (cnt_q == 2'd1 && out_ready_i);

  always_comb begin
    slots_d = slots_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      slots_d = grp_i.recs;
      cnt_d   = grp_i.n;
    end else if (pop) begin
      slots_d[0] = slots_q[1];
      slots_d[1] = slots_q[2];
      cnt_d      = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

  assign rec_o       = slots_q[0];
  assign out_valid_o = (cnt_q != '0);
  assign last_o      = (cnt_q == 2'd1);

  `EISP_ASSERT(a_load_when_drained,
      load_i |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)),
      "group loaded over undelivered records")
  `EISP_ASSERT(a_stall_holds,
      (cnt_q != 2'd0 && !out_ready_i && !load_i) |=>
        ($stable(slots_q[0]) && cnt_q == $past(cnt_q)),
      "stalled record changed")
  `EISP_ASSERT(a_load_shows,
      (load_i && grp_i.n != 2'd0) |=> (out_valid_o && cnt_q == $past(grp_i.n)),
      "loaded group not presented")
  `EISP_ASSERT(a_cnt_max, cnt_q != 2'd3 || !last_o, "last flag with full buffer")

endmodule

[hw/rtl/event_info_section_parser_core.sv]
// Event information section parser: one section byte in, tagged field records out.
// Path: an accepted byte waits in the input register, then loads its records into the
//   result buffer, which drains one record per cycle while out_ready_i is high; so the
//   input takes one byte per cycle while each byte yields at most one record, else waits.
// Reset: asynchronous, active low; parser returns to the header phase with counters cleared.

module event_info_section_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        section_start_i,
  // record output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  field_code_o,
  output logic [39:0] field_value_o,
  output logic [8:0]  event_number_o,
  output logic [10:0] descriptor_number_o,
  output logic        last_of_run_o
);

  // Input register: holds one accepted transaction until the parser can
  // hand its records to the result buffer.
  logic       inq_valid_q;
  logic [7:0] inq_byte_q;
  logic       inq_start_q;

  logic           can_load;
  logic           advance;
  eisp_pkg::grp_t grp;
  eisp_pkg::rec_t rec;

  // Advance the held byte once the result buffer is empty, or is
  // releasing its final record in this same cycle.
  assign advance    = inq_valid_q && can_load;
  assign in_ready_o = !inq_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      inq_byte_q  <= data_byte_i;
      inq_start_q <= section_start_i;
    end
  end

  // Parse step: all state updates and up to three records for one byte.
  eisp_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (advance),
    .data_byte_i     (inq_byte_q),
    .section_start_i (inq_start_q),
    .grp_o           (grp)
  );

  // Result buffer: holds one byte's records and presents them in order.
  eisp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .grp_i       (grp),
    .can_load_o  (can_load),
    .rec_o       (rec),
    .out_valid_o (out_valid_o),
    .last_o      (last_of_run_o),
    .out_ready_i (out_ready_i)
  );

  assign field_code_o        = rec.code;
  assign field_value_o       = rec.value;
  assign event_number_o      = rec.event_num;
  assign descriptor_number_o = rec.desc_num;

endmodule

[tb/tb_event_info_section_parser_core.sv]
module tb_event_info_section_parser_core;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned TargetBytes  = 160;

  // Parser position within a section, mirrored from the block's behavior.
  typedef enum logic [2:0] {
    ST_HEADER,
    ST_EVENT,
    ST_DESC_TAG,
    ST_DESC_LEN,
    ST_DESC_BODY,
    ST_SKIP,
    ST_IDLE
  } parse_state_e;

  // One expected field record, as it should leave the output channel.
  typedef struct {
    eisp_pkg::field_code_e       code;
    logic [eisp_pkg::ValueW-1:0] value;
    logic [eisp_pkg::EventW-1:0] event_num;
    logic [eisp_pkg::DescW-1:0]  desc_num;
    logic                        last;
  } field_rec_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i     = 8'h00;
  logic        section_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [4:0]  field_code_o;
  logic [39:0] field_value_o;
  logic [8:0]  event_number_o;
  logic [10:0] descriptor_number_o;
  logic        last_of_run_o;

  event_info_section_parser_core DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .section_start_i     (section_start_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .field_code_o        (field_code_o),
    .field_value_o       (field_value_o),
    .event_number_o      (event_number_o),
    .descriptor_number_o (descriptor_number_o),
    .last_of_run_o       (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Section parser state, advanced once per accepted byte.
  logic [12:0]  pos_cnt;
  logic [11:0]  sec_len;
  parse_state_e state;
  logic [3:0]   ev_pos;
  logic [11:0]  loop_left;
  logic [8:0]   desc_left;
  logic [8:0]   ev_idx;
  logic [10:0]  desc_idx;
  logic [39:0]  shift_acc;

  field_rec_t expected_fields[$];  // records still owed by the block, oldest first
  field_rec_t byte_fields[$];      // records caused by the byte being parsed
  field_rec_t head_rec;

  logic [7:0] sect_bytes[$];       // section under construction for the random part

  int mismatch_count = 0;
  int parsed_bytes   = 0;          // accepted bytes that the parser did not ignore
  int cycle_count    = 0;
  int steady_left    = 0;          // remaining sends with no gap in a burst
  int ready_hold     = 0;
  int ready_roll;

  // ---------------------------------------------------------------------------
  // Field record prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_parser();
    pos_cnt   = '0;
    sec_len   = '0;
    state     = ST_HEADER;
    ev_pos    = '0;
    loop_left = '0;
    desc_left = '0;
    ev_idx    = '0;
    desc_idx  = '0;
    shift_acc = '0;
  endfunction

  function automatic void emit(eisp_pkg::field_code_e c, logic [39:0] v, logic [8:0] e,
                               logic [10:0] d);
    byte_fields.push_back('{c, v, e, d, 1'b0});
  endfunction

  // Close the current event and look for the next event start byte.
  function automatic void advance_event();
    ev_idx   = ev_idx + 9'd1;
    desc_idx = '0;
    ev_pos   = '0;
    state    = ST_EVENT;
  endfunction

  // Parse one accepted byte and queue the records it owes. Return 0 for an ignored byte.
  function automatic bit parse_byte(logic [7:0] b, logic st);
    if (st) clear_parser();
    if (state == ST_IDLE) return 1'b0;
    byte_fields.delete();
    shift_acc = {shift_acc[31:0], b};

    // The event area closes where the CRC begins, whatever was half read.
    if (state >= ST_EVENT && state <= ST_DESC_BODY && int'(pos_cnt) + 1 >= int'(sec_len))
      state = ST_SKIP;

    case (state)
      ST_HEADER: begin
        case (pos_cnt)
          13'd0: emit(eisp_pkg::FC_TABLE_ID, 40'(b), '0, '0);
          13'd2: begin
            sec_len = shift_acc[11:0];
            emit(eisp_pkg::FC_SECTION_LEN, 40'(sec_len), '0, '0);
          end
          13'd4: emit(eisp_pkg::FC_SERVICE_ID, 40'(shift_acc[15:0]), '0, '0);
          13'd5: begin
            emit(eisp_pkg::FC_VERSION, 40'(b[5:1]), '0, '0);
            emit(eisp_pkg::FC_CURRENT_NEXT, 40'(b[0]), '0, '0);
          end
          13'd6:  emit(eisp_pkg::FC_SECTION_NUM, 40'(b), '0, '0);
          13'd7:  emit(eisp_pkg::FC_LAST_SECTION, 40'(b), '0, '0);
          13'd9:  emit(eisp_pkg::FC_TS_ID, 40'(shift_acc[15:0]), '0, '0);
          13'd11: emit(eisp_pkg::FC_NETWORK_ID, 40'(shift_acc[15:0]), '0, '0);
          13'd12: emit(eisp_pkg::FC_SEG_LAST_SECT, 40'(b), '0, '0);
          13'd13: begin
            emit(eisp_pkg::FC_LAST_TABLE_ID, 40'(b), '0, '0);
            state  = ST_EVENT;
            ev_pos = '0;
          end
          default: ;
        endcase
      end
      ST_EVENT: begin
        if (ev_pos == 4'd0 && b == 8'hff) begin
          // Stuffing byte where an event would start: stop event parsing.
          state = ST_SKIP;
        end else begin
          case (ev_pos)
            4'd1:  emit(eisp_pkg::FC_EVENT_ID, 40'(shift_acc[15:0]), ev_idx, '0);
            4'd6:  emit(eisp_pkg::FC_START_TIME, shift_acc, ev_idx, '0);
            4'd9:  emit(eisp_pkg::FC_DURATION, 40'(shift_acc[23:0]), ev_idx, '0);
            4'd10: emit(eisp_pkg::FC_RUNNING, 40'(b[7:5]), ev_idx, '0);
            default: ;
          endcase
          if (ev_pos >= 4'd11) begin
            loop_left = shift_acc[11:0];
            emit(eisp_pkg::FC_LOOP_LEN, 40'(loop_left), ev_idx, '0);
            if (loop_left == '0) begin
              advance_event();
            end else begin
              desc_idx = '0;
              state    = ST_DESC_TAG;
            end
          end else begin
            ev_pos = ev_pos + 4'd1;
          end
        end
      end
      ST_DESC_TAG: begin
        emit(eisp_pkg::FC_DESC_TAG, 40'(b), ev_idx, desc_idx);
        loop_left = loop_left - 12'd1;
        if (loop_left == '0) advance_event();
        else state = ST_DESC_LEN;
      end
      ST_DESC_LEN: begin
        emit(eisp_pkg::FC_DESC_LEN, 40'(b), ev_idx, desc_idx);
        loop_left = loop_left - 12'd1;
        desc_left = 9'(b);
        if (loop_left == '0) begin
          advance_event();
        end else if (desc_left == '0) begin
          desc_idx = desc_idx + 11'd1;
          state    = ST_DESC_TAG;
        end else begin
          state = ST_DESC_BODY;
        end
      end
      ST_DESC_BODY: begin
        // A descriptor that overruns its loop is cut where the loop ends.
        loop_left = loop_left - 12'd1;
        desc_left = desc_left - 9'd1;
        if (loop_left == '0) begin
          advance_event();
        end else if (desc_left == '0) begin
          desc_idx = desc_idx + 11'd1;
          state    = ST_DESC_TAG;
        end
      end
      default: ;
    endcase

    // The last CRC byte closes the section; further bytes wait for a start mark.
    if (pos_cnt >= 13'd2 && int'(pos_cnt) == int'(sec_len) + 2) begin
      emit(eisp_pkg::FC_END, '0, '0, '0);
      state = ST_IDLE;
    end else begin
      pos_cnt = pos_cnt + 13'd1;
    end

    if (byte_fields.size() > 0) byte_fields[byte_fields.size()-1].last = 1'b1;
    foreach (byte_fields[i]) expected_fields.push_back(byte_fields[i]);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte channel driver
  // ---------------------------------------------------------------------------

  // Mostly no gap or a short one, now and then a long one, and bursts with none.
  function automatic int pick_gap();
    int roll;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      steady_left = $urandom_range(15, 50);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Present one byte, hold it until the transaction completes, then predict its records.
  // Valid is only lowered when a gap follows, so a back-to-back byte keeps it high.
  task automatic send_byte(logic [7:0] b, logic st);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    section_start_i <= st;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (parse_byte(b, st)) parsed_bytes++;
  endtask

  // Drop valid and hold off until every owed record has been delivered.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_fields.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random section builder
  // ---------------------------------------------------------------------------

  // Build a section in sect_bytes. Most are well formed with random content: events
  // with empty loops, zero-length descriptors, loops that cut a descriptor short, loops
  // that run into the CRC, and a stuffing byte ending the event area. A few are short
  // sections or are cut off early so the next start mark drops them.
  task automatic build_section(output bit complete);
    logic [7:0] loop_bytes[$];
    logic [7:0] body[$];
    int n_events, n_desc, d_len, loop_len, shape, len_field, keep, roll;
    n_events = $urandom_range(0, 3);
    for (int e = 0; e < n_events; e++) begin
      loop_bytes.delete();
      shape = $urandom_range(0, 9);
      if (shape > 0) begin
        n_desc = $urandom_range(1, 3);
        for (int d = 0; d < n_desc; d++) begin
          loop_bytes.push_back(8'($urandom));
          d_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          loop_bytes.push_back(8'(d_len));
          repeat (d_len) loop_bytes.push_back(8'($urandom));
        end
      end
      loop_len = loop_bytes.size();
      if (shape == 1)
        loop_len = $urandom_range(0, 4095);
      else if (shape == 2 && loop_len > 1)
        loop_len = loop_len - $urandom_range(1, loop_len - 1);
      repeat (10) body.push_back(8'($urandom));
      body.push_back({4'($urandom), 4'(loop_len >> 8)});
      body.push_back(8'(loop_len));
      foreach (loop_bytes[i]) body.push_back(loop_bytes[i]);
    end
    if ($urandom_range(0, 5) == 0) begin
      body.push_back(8'hff);
      repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
    end

    roll = $urandom_range(0, 7);
    if (roll == 0) len_field = $urandom_range(0, 12);
    else if (roll == 1) len_field = $urandom_range(0, 4095);
    else len_field = 15 + body.size();

    sect_bytes.delete();
    sect_bytes.push_back(8'($urandom));
    sect_bytes.push_back({4'($urandom), 4'(len_field >> 8)});
    sect_bytes.push_back(8'(len_field));
    repeat (11) sect_bytes.push_back(8'($urandom));
    foreach (body[i]) sect_bytes.push_back(body[i]);
    repeat (4) sect_bytes.push_back(8'($urandom));

    keep = (roll == 1) ? $urandom_range(1, sect_bytes.size()) : len_field + 3;
    while (sect_bytes.size() > keep) void'(sect_bytes.pop_back());
    complete = (roll != 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // First byte after reset carries no start mark and still opens a section. Section
  // length 3 makes the version byte the last one, so it yields three records; the byte
  // after the end is ignored.
  task automatic test_headerless_section();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5a, 1'b0);
  endtask

  // Abandon a section partway through its header; the next start mark takes over.
  task automatic test_restart_mid_section();
    send_byte(8'h4e, 1'b1);
    send_byte(8'h7a, 1'b0);
    send_byte(8'hbc, 1'b0);
  endtask

  // All-ones header: maximum section length and every header field at its top value.
  // The first event byte is 0xff, which closes the event area.
  task automatic test_header_all_ones();
    send_byte(8'hff, 1'b1);
    repeat (16) send_byte(8'hff, 1'b0);
  endtask

  task automatic test_random_sections();
    int  base;
    bit  complete;
    base = parsed_bytes;
    // Let the record stream run dry before the random part begins.
    wait_drained();
    while (parsed_bytes - base < int'(TargetBytes)) begin
      build_section(complete);
      foreach (sect_bytes[i]) send_byte(sect_bytes[i], i == 0);
      // Trailing bytes after a closed section must be ignored.
      if (complete && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      if ($urandom_range(0, 4) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Record channel: random back-pressure and checking
  // ---------------------------------------------------------------------------

  // Hold ready for runs of random length: mostly short stalls, some long, some long
  // stretches with no stall at all.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_roll = $urandom_range(0, 15);
      if (ready_roll < 9) begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end else if (ready_roll < 14) begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else if (ready_roll == 14) begin
        out_ready_i <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end else begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(40, 150);
      end
    end
  end

  // Compare every delivered record against the oldest one still owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_fields.size() == 0) begin
        $error("field_code: expected none, got %0d", field_code_o);
        mismatch_count++;
      end else begin
        head_rec = expected_fields.pop_front();
        if (field_code_o !== head_rec.code) begin
          $error("field_code: expected %0d, got %0d", head_rec.code, field_code_o);
          mismatch_count++;
        end
        if (field_value_o !== head_rec.value) begin
          $error("field_value: expected %0h, got %0h", head_rec.value, field_value_o);
          mismatch_count++;
        end
        if (event_number_o !== head_rec.event_num) begin
          $error("event_number: expected %0d, got %0d", head_rec.event_num, event_number_o);
          mismatch_count++;
        end
        if (descriptor_number_o !== head_rec.desc_num) begin
          $error("descriptor_number: expected %0d, got %0d", head_rec.desc_num,
                 descriptor_number_o);
          mismatch_count++;
        end
        if (last_of_run_o !== head_rec.last) begin
          $error("last_of_run: expected %0d, got %0d", head_rec.last, last_of_run_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > int'(CycleLimit)) begin
      $display("event_info_section_parser_core: mismatch");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_headerless_section();
    test_restart_mid_section();
    test_header_all_ones();
    test_random_sections();

    // Drain the record stream, then give stray records time to show up.
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_fields.size() == 0)
      $display("event_info_section_parser_core: match");
    else
      $display("event_info_section_parser_core: mismatch");
    $finish;
  end

endmodule
